FILE: rtl/core/drum_sample_voice_mixer_top_macros.svh
// Assertion macros for the drum sample voice mixer.
`ifndef DRUM_SAMPLE_VOICE_MIXER_TOP_MACROS_SVH
`define DRUM_SAMPLE_VOICE_MIXER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define DSVM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dsvm: same-cycle check failed");
// Next-cycle implication.
`define DSVM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dsvm: next-cycle check failed");
`else
`define DSVM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DSVM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/dsvm_pkg.sv
// Types and constants of the drum sample voice mixer.
package dsvm_pkg;

	localparam int OPCODE_W = 2;
	localparam int NOTE_W = 7;
	localparam int VEL_W = 8;
	localparam int SIDX_W = 4;
	localparam int SSTART_W = 16;
	localparam int SLEN_W = 17;
	localparam int SADDR_W = 16;
	localparam int SAMPLE_W = 16;
	localparam int SCOUNT_W = 5;

	localparam int SLICE_COUNT = 16;
	localparam int SAMPLE_WORDS = 65536;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 7;

	localparam int IN_FIELDS_W = NOTE_W + VEL_W + SIDX_W + SSTART_W + SLEN_W + SADDR_W
		+ SAMPLE_W;
	localparam int IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int IN_PAD_W = IN_TDATA_W - IN_FIELDS_W;

	localparam logic [NOTE_W-1:0] BASE_NOTE_RESET = 7'd36;

	// x / 127 for x below 2^23: (x * ceil(2^30 / 127)) >> 30
	localparam int PROD_W = 23;
	localparam int RECIP_W = 24;
	localparam logic [RECIP_W-1:0] DIV127_RECIP = 24'd8454661;
	localparam int DIV127_SHIFT = 30;
	localparam int QUOT_W = 17;
	localparam int SUM_W = 18;

	localparam logic signed [SUM_W-1:0] MIX_MAX = 18'sd32767;
	localparam logic signed [SUM_W-1:0] MIX_MIN = -18'sd32768;

	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK = 2'd0,
		OP_NOTE_ON = 2'd1,
		OP_LOAD_SLICE = 2'd2,
		OP_LOAD_SAMPLE = 2'd3
	} opcode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BASE_NOTE = 1'd0,
		REG_SLICE_COUNT = 1'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NOTE,
		ST_MIX,
		ST_DRAIN
	} state_t;

	// Input beat, first field in the lowest bits.
	typedef struct packed {
		logic [IN_PAD_W-1:0] pad;
		logic [SAMPLE_W-1:0] sample_value;
		logic [SADDR_W-1:0] sample_address;
		logic [SLEN_W-1:0] slice_length;
		logic [SSTART_W-1:0] slice_start;
		logic [SIDX_W-1:0] slice_index;
		logic [VEL_W-1:0] velocity;
		logic [NOTE_W-1:0] note;
	} in_beat_t;

endpackage

FILE: rtl/core/dsvm_ram.sv
// Generic single-port-write, registered-read RAM.
module dsvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/drum_sample_voice_mixer_top.sv
// Top level of the drum sample voice mixer: sequencer, voice state and mix pipeline.
//
// Items arrive on the s_axis channel, opcode in tuser. A tick returns one mixed word on
// m_axis; note-on and load items return nothing. Loads write the slice table or the
// sample memory in the accepting cycle and silence every voice.
// A note-on in range scans the voices one per cycle looking for a free voice, else the
// voice with the largest position. Out-of-range notes start no voice.
// A tick walks the voices one per cycle through a four-stage unit (sample read, gain
// multiply, divide by 127, saturating add); the one sample memory read port is shared
// by all voices.
// s_axis_tready is high only while the sequencer is idle. The result sits in an output
// register, so loads and note-ons are taken while it waits; a following tick holds its
// finished word until the receiver takes the previous one.
// Reset clears all voices, sets base_note to 36 and slice_count to 0. The sample memory
// and slice table are undefined until written. The cfg port is always ready; it is to be
// written only while the block is idle, which the block itself does not enforce.
`include "drum_sample_voice_mixer_top_macros.svh"

module drum_sample_voice_mixer_top
	import dsvm_pkg::*;
#(
	parameter int VOICE_COUNT = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// note, velocity, slice_index, slice_start, slice_length, sample_address, sample_value
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// opcode
	input  logic [OPCODE_W-1:0]    s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// mixed_sample
	output logic [SAMPLE_W-1:0]    m_axis_tdata
);

	localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICE_COUNT - 1);

	state_t state_q, state_d;
	logic [VIDX_W-1:0] vidx_q;

	logic [NOTE_W-1:0] base_note_q;
	logic [SCOUNT_W-1:0] slice_count_q;

	logic [VOICE_COUNT-1:0] act_q;
	logic [SIDX_W-1:0] vslice_q [VOICE_COUNT];
	logic [SLEN_W-1:0] vpos_q [VOICE_COUNT];
	logic [VEL_W-1:0] vgain_q [VOICE_COUNT];

	logic [SSTART_W-1:0] tstart_q [SLICE_COUNT];
	logic [SLEN_W-1:0] tlen_q [SLICE_COUNT];

	logic [SIDX_W-1:0] nidx_q;
	logic [VEL_W-1:0] ngain_q;
	logic [SLEN_W-1:0] best_pos_q;
	logic [VIDX_W-1:0] pick_q;

	logic v_s1, v_s2, v_s3;
	logic [VEL_W-1:0] gain_s1;
	logic [PROD_W-1:0] prod_s2;
	logic neg_s2;
	logic [QUOT_W-1:0] quot_s3;
	logic neg_s3;
	logic signed [SAMPLE_W-1:0] mix_q;

	logic out_valid_q;
	logic [SAMPLE_W-1:0] out_data_q;

	in_beat_t beat;
	opcode_t op;
	logic in_acc, is_load, out_load, mix_step, pipe_busy;
	logic [NOTE_W-1:0] note_rel;
	logic [SCOUNT_W-1:0] slice_limit;
	logic note_ok;

	logic cur_act;
	logic [SIDX_W-1:0] cur_slice;
	logic [SLEN_W-1:0] cur_pos, cur_len, pos_inc;
	logic [SSTART_W-1:0] cur_start;
	logic play, free;
	logic [SADDR_W-1:0] rd_addr;

	logic scan_better, note_wr;
	logic [VIDX_W-1:0] note_pick;

	logic [SAMPLE_W-1:0] ram_rdata;
	logic [SAMPLE_W-1:0] mag;
	logic [SAMPLE_W+VEL_W-1:0] prod_full;
	logic [PROD_W+RECIP_W-1:0] recip_full;
	logic signed [SUM_W-1:0] contrib, sum;
	logic signed [SAMPLE_W-1:0] mix_sat;

	assign beat = in_beat_t'(s_axis_tdata);
	assign op = opcode_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign is_load = (op == OP_LOAD_SLICE) || (op == OP_LOAD_SAMPLE);
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	// Note-on range check against the loaded kit
	assign note_rel = beat.note - base_note_q;
	assign slice_limit = (slice_count_q > SCOUNT_W'(SLICE_COUNT)) ? SCOUNT_W'(SLICE_COUNT)
		: slice_count_q;
	assign note_ok = (beat.note >= base_note_q) && (note_rel < NOTE_W'(slice_limit));

	// Voice under the sequencer
	assign cur_act = act_q[vidx_q];
	assign cur_slice = vslice_q[vidx_q];
	assign cur_pos = vpos_q[vidx_q];
	assign cur_len = tlen_q[cur_slice];
	assign cur_start = tstart_q[cur_slice];
	assign pos_inc = cur_pos + SLEN_W'(1);
	assign play = cur_act && (cur_pos < cur_len);
	assign free = cur_act && (!play || (pos_inc >= cur_len));
	assign rd_addr = cur_start + cur_pos[SADDR_W-1:0];

	// Voice allocation: first free voice, else strictly largest position
	assign scan_better = cur_pos > best_pos_q;
	assign note_pick = (!cur_act || scan_better) ? vidx_q : pick_q;
	assign note_wr = (state_q == ST_NOTE) && (!cur_act || (vidx_q == LAST_VOICE));

	assign pipe_busy = v_s1 || v_s2 || v_s3;

	always_comb begin
		state_d = state_q;
		out_load = 1'b0;
		mix_step = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (op)
						OP_TICK: state_d = ST_MIX;
						OP_NOTE_ON: state_d = note_ok ? ST_NOTE : ST_IDLE;
						OP_LOAD_SLICE, OP_LOAD_SAMPLE: state_d = ST_IDLE;
					endcase
				end
			end
			ST_NOTE: begin
				if (note_wr) begin
					state_d = ST_IDLE;
				end
			end
			ST_MIX: begin
				mix_step = 1'b1;
				if (vidx_q == LAST_VOICE) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// hold the finished word until the output register frees up
				if (!pipe_busy && (!out_valid_q || m_axis_tready)) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vidx_q <= '0;
			base_note_q <= BASE_NOTE_RESET;
			slice_count_q <= '0;
			act_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			mix_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_NOTE) || (state_q == ST_MIX)) begin
				vidx_q <= vidx_q + VIDX_W'(1);
			end else begin
				vidx_q <= '0;
			end

			if (cfg_valid) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_BASE_NOTE: base_note_q <= cfg_data[NOTE_W-1:0];
					REG_SLICE_COUNT: slice_count_q <= cfg_data[SCOUNT_W-1:0];
				endcase
			end

			// any load silences the kit
			if (in_acc && is_load) begin
				act_q <= '0;
			end else if (note_wr) begin
				act_q[note_pick] <= 1'b1;
			end else if (mix_step && free) begin
				act_q[vidx_q] <= 1'b0;
			end

			v_s1 <= mix_step && play;
			v_s2 <= v_s1;
			v_s3 <= v_s2;

			if (in_acc && (op == OP_TICK)) begin
				mix_q <= '0;
			end else if (v_s3) begin
				mix_q <= mix_sat;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (note_wr) begin
			vslice_q[note_pick] <= nidx_q;
			vpos_q[note_pick] <= '0;
			vgain_q[note_pick] <= ngain_q;
		end else if (mix_step && play) begin
			vpos_q[vidx_q] <= pos_inc;
		end

		if (in_acc && (op == OP_LOAD_SLICE)) begin
			tstart_q[beat.slice_index] <= beat.slice_start;
			tlen_q[beat.slice_index] <= beat.slice_length;
		end

		if (in_acc) begin
			nidx_q <= note_rel[SIDX_W-1:0];
			ngain_q <= beat.velocity;
			best_pos_q <= '0;
			pick_q <= '0;
		end else if ((state_q == ST_NOTE) && cur_act && scan_better) begin
			best_pos_q <= cur_pos;
			pick_q <= vidx_q;
		end

		gain_s1 <= vgain_q[vidx_q];
		prod_s2 <= prod_full[PROD_W-1:0];
		neg_s2 <= ram_rdata[SAMPLE_W-1];
		quot_s3 <= recip_full[DIV127_SHIFT +: QUOT_W];
		neg_s3 <= neg_s2;

		if (out_load) begin
			out_data_q <= mix_q;
		end
	end

	dsvm_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(SAMPLE_WORDS)
	) u_sample_ram (
		.clk  (clk),
		.we   (in_acc && (op == OP_LOAD_SAMPLE)),
		.waddr(beat.sample_address),
		.wdata(beat.sample_value),
		.re   (mix_step && play),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// Stage 2: sign-magnitude product; the divide truncates toward zero
	assign mag = ram_rdata[SAMPLE_W-1] ? (~ram_rdata + SAMPLE_W'(1)) : ram_rdata;
	assign prod_full = mag * gain_s1;

	// Stage 3: divide by 127 through the reciprocal
	assign recip_full = prod_s2 * DIV127_RECIP;

	// Stage 4: saturating accumulate
	assign contrib = neg_s3 ? -signed'({1'b0, quot_s3}) : signed'({1'b0, quot_s3});
	assign sum = SUM_W'(mix_q) + contrib;
	always_comb begin
		priority if (sum > MIX_MAX) begin
			mix_sat = MIX_MAX[SAMPLE_W-1:0];
		end else if (sum < MIX_MIN) begin
			mix_sat = MIX_MIN[SAMPLE_W-1:0];
		end else begin
			mix_sat = sum[SAMPLE_W-1:0];
		end
	end

	`DSVM_ASSERT_IMP(a_pipe_in_tick, clk, arst_n, (v_s1 || v_s2 || v_s3), (state_q == ST_MIX || state_q == ST_DRAIN))
	`DSVM_ASSERT_NXT(a_note_takes_voice, clk, arst_n, note_wr, act_q[$past(note_pick)])
	`DSVM_ASSERT_IMP(a_no_result_overwrite, clk, arst_n, (out_valid_q && !m_axis_tready), !out_load)

endmodule

FILE: test/tb.sv
// Self-checking testbench for the drum sample voice mixer: directed rows, then random kits.
`timescale 1ns / 1ps

module tb;
	import dsvm_pkg::*;

	localparam int VOICES = 8;
	localparam int RANDOM_ITEMS = 1900;
	localparam int SETTLE_CYCLES = 24;
	localparam int STALL_LIMIT = 2000;

	typedef enum bit {ROW_BEAT, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		opcode_t op;
		in_beat_t beat;
		cfg_reg_t cfg_sel;
		logic [CFG_DATA_W-1:0] cfg_val;
		bit typed;
		logic [SAMPLE_W-1:0] want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = REG_BASE_NOTE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	in_beat_t s_axis_tdata = '0;
	opcode_t s_axis_tuser = OP_TICK;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [SAMPLE_W-1:0] m_axis_tdata;

	drum_sample_voice_mixer_top #(
		.VOICE_COUNT(VOICES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mirror of the block: kit memory, slice table, voices, registers.
	logic [SAMPLE_W-1:0] kit_mem [0:SAMPLE_WORDS-1];
	bit word_written [0:SAMPLE_WORDS-1];
	logic [SSTART_W-1:0] slice_first [0:SLICE_COUNT-1];
	logic [SLEN_W-1:0] slice_words [0:SLICE_COUNT-1];
	bit slice_written [0:SLICE_COUNT-1];
	bit voice_on [0:VOICES-1];
	logic [SIDX_W-1:0] voice_slice [0:VOICES-1];
	logic [SLEN_W-1:0] voice_pos [0:VOICES-1];
	logic [VEL_W-1:0] voice_gain [0:VOICES-1];
	logic [NOTE_W-1:0] base_note_q = BASE_NOTE_RESET;
	logic [SCOUNT_W-1:0] slice_count_q = '0;

	logic [SAMPLE_W-1:0] mix_queue [$];
	stim_row_t stim_rows [$];

	int mismatches = 0;
	int beats_taken = 0;
	int notes_ignored = 0;
	int notes_started = 0;
	int steals = 0;
	int loads = 0;
	int mixes_checked = 0;
	int cfg_writes = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int epoch_no = 0;

	task automatic note_mismatch(string what, logic [SAMPLE_W-1:0] got,
			logic [SAMPLE_W-1:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch %s at %0t: got %h want %h", what, $realtime, got, want);
	endtask

	function automatic void silence_voices();
		for (int v = 0; v < VOICES; v++)
			voice_on[v] = 1'b0;
	endfunction

	function automatic int slice_limit();
		return (slice_count_q > SLICE_COUNT) ? SLICE_COUNT : int'(slice_count_q);
	endfunction

	// Start a voice on the note's slice; free voice first, else steal the furthest one.
	function automatic bit start_voice(logic [NOTE_W-1:0] note, logic [VEL_W-1:0] gain);
		int idx;
		int pick;
		logic [SLEN_W-1:0] best;
		bit all_busy;
		if (note < base_note_q)
			return 1'b0;
		idx = note - base_note_q;
		if (idx >= slice_limit())
			return 1'b0;
		pick = 0;
		best = '0;
		all_busy = 1'b1;
		for (int v = 0; v < VOICES; v++) begin
			if (!voice_on[v]) begin
				pick = v;
				all_busy = 1'b0;
				break;
			end
			if (voice_pos[v] > best) begin
				best = voice_pos[v];
				pick = v;
			end
		end
		if (all_busy)
			steals++;
		voice_on[pick] = 1'b1;
		voice_slice[pick] = idx[SIDX_W-1:0];
		voice_pos[pick] = '0;
		voice_gain[pick] = gain;
		return 1'b1;
	endfunction

	// One mixed word: scale each active voice, saturate after every add, advance.
	function automatic logic [SAMPLE_W-1:0] mix_tick();
		int acc;
		int smp;
		int part;
		int s;
		logic [SADDR_W-1:0] addr;
		acc = 0;
		for (int v = 0; v < VOICES; v++) begin
			if (!voice_on[v])
				continue;
			s = voice_slice[v];
			if (voice_pos[v] < slice_words[s]) begin
				addr = slice_first[s] + voice_pos[v][SADDR_W-1:0];
				smp = $signed(kit_mem[addr]);
				part = smp * int'(voice_gain[v]) / 127;
				acc += part;
				if (acc > 32767)
					acc = 32767;
				if (acc < -32768)
					acc = -32768;
				voice_pos[v] = voice_pos[v] + 1'b1;
			end
			if (voice_pos[v] >= slice_words[s])
				voice_on[v] = 1'b0;
		end
		return acc[SAMPLE_W-1:0];
	endfunction

	// Find a word the next tick would read that was never loaded.
	function automatic bit tick_is_safe(output logic [SADDR_W-1:0] missing);
		int s;
		logic [SADDR_W-1:0] addr;
		missing = '0;
		for (int v = 0; v < VOICES; v++) begin
			if (!voice_on[v])
				continue;
			s = voice_slice[v];
			if (voice_pos[v] < slice_words[s]) begin
				addr = slice_first[s] + voice_pos[v][SADDR_W-1:0];
				if (!word_written[addr]) begin
					missing = addr;
					return 1'b0;
				end
			end
		end
		return 1'b1;
	endfunction

	function automatic bit note_is_safe(int note);
		int idx;
		if (note < base_note_q)
			return 1'b1;
		idx = note - base_note_q;
		return (idx >= slice_limit()) || slice_written[idx];
	endfunction

	function automatic in_beat_t noise_beat();
		in_beat_t b;
		b = {$urandom, $urandom, $urandom};
		b.pad = '0;
		return b;
	endfunction

	function automatic in_beat_t note_beat(in_beat_t b, logic [NOTE_W-1:0] note,
			logic [VEL_W-1:0] vel);
		b.note = note;
		b.velocity = vel;
		return b;
	endfunction

	function automatic in_beat_t slice_beat(in_beat_t b, logic [SIDX_W-1:0] idx,
			logic [SSTART_W-1:0] first, logic [SLEN_W-1:0] len);
		b.slice_index = idx;
		b.slice_start = first;
		b.slice_length = len;
		return b;
	endfunction

	function automatic in_beat_t sample_beat(in_beat_t b, logic [SADDR_W-1:0] addr,
			logic [SAMPLE_W-1:0] val);
		b.sample_address = addr;
		b.sample_value = val;
		return b;
	endfunction

	function automatic void add_beat(opcode_t op, in_beat_t b, bit typed,
			logic [SAMPLE_W-1:0] want);
		stim_row_t row;
		row.kind = ROW_BEAT;
		row.op = op;
		row.beat = b;
		row.cfg_sel = REG_BASE_NOTE;
		row.cfg_val = '0;
		row.typed = typed;
		row.want = want;
		stim_rows.push_back(row);
	endfunction

	function automatic void add_cfg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] val);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.op = OP_TICK;
		row.beat = '0;
		row.cfg_sel = sel;
		row.cfg_val = val;
		row.typed = 1'b0;
		row.want = '0;
		stim_rows.push_back(row);
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [VEL_W-1:0] rand_vel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd127;
			2: return 8'd255;
			default: return $urandom;
		endcase
	endfunction

	// Send one beat in bursts with random gaps, then update the mirror on acceptance.
	task automatic put_beat(opcode_t op, in_beat_t b, bit typed, logic [SAMPLE_W-1:0] want);
		int gap;
		logic [SAMPLE_W-1:0] got;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		beats_taken++;
		case (op)
			OP_TICK: begin
				got = mix_tick();
				mix_queue.push_back(typed ? want : got);
			end
			OP_NOTE_ON: begin
				if (start_voice(b.note, b.velocity))
					notes_started++;
				else
					notes_ignored++;
			end
			OP_LOAD_SLICE: begin
				silence_voices();
				slice_first[b.slice_index] = b.slice_start;
				slice_words[b.slice_index] = b.slice_length;
				slice_written[b.slice_index] = 1'b1;
				loads++;
			end
			OP_LOAD_SAMPLE: begin
				silence_voices();
				kit_mem[b.sample_address] = b.sample_value;
				word_written[b.sample_address] = 1'b1;
				loads++;
			end
		endcase
	endtask

	// Write a register once the block has drained.
	task automatic set_register(cfg_reg_t sel, logic [CFG_DATA_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		while (mix_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cfg_writes++;
		if (sel == REG_BASE_NOTE)
			base_note_q = val[NOTE_W-1:0];
		else
			slice_count_q = val[SCOUNT_W-1:0];
	endtask

	task automatic send_load_sample(logic [SADDR_W-1:0] addr, logic [SAMPLE_W-1:0] val);
		put_beat(OP_LOAD_SAMPLE, sample_beat(noise_beat(), addr, val), 1'b0, '0);
	endtask

	task automatic send_load_slice(logic [SIDX_W-1:0] idx, logic [SSTART_W-1:0] first,
			logic [SLEN_W-1:0] len);
		put_beat(OP_LOAD_SLICE, slice_beat(noise_beat(), idx, first, len), 1'b0, '0);
	endtask

	// A tick that would read an unloaded word becomes a load of that word instead.
	task automatic send_tick();
		logic [SADDR_W-1:0] missing;
		if (tick_is_safe(missing))
			put_beat(OP_TICK, noise_beat(), 1'b0, '0);
		else
			send_load_sample(missing, rand_word());
	endtask

	task automatic send_note();
		int lim;
		int nt;
		lim = slice_limit();
		if (lim > 0 && $urandom_range(0, 5) != 0)
			nt = base_note_q + $urandom_range(0, lim - 1);
		else
			nt = $urandom_range(0, 127);
		if (nt > 127 || !note_is_safe(nt))
			nt = $urandom_range(0, 127);
		if (!note_is_safe(nt))
			return;
		put_beat(OP_NOTE_ON, note_beat(noise_beat(), nt[NOTE_W-1:0], rand_vel()), 1'b0, '0);
	endtask

	task automatic pick_config();
		int bn;
		int sc;
		case ($urandom_range(0, 5))
			0: bn = 0;
			1: bn = 127;
			2: bn = 36;
			default: bn = $urandom_range(0, 110);
		endcase
		case ($urandom_range(0, 6))
			0: sc = 0;
			1: sc = 16;
			2: sc = 31;
			default: sc = $urandom_range(1, 16);
		endcase
		if ($urandom_range(0, 3) != 0)
			set_register(REG_BASE_NOTE, bn[CFG_DATA_W-1:0]);
		// upper data bits are don't-care for the count; toggle them anyway
		set_register(REG_SLICE_COUNT, {2'($urandom), sc[SCOUNT_W-1:0]});
	endtask

	// One kit: load a word region and slices inside it, then play notes and ticks.
	task automatic run_epoch();
		int n_words;
		int region;
		int n_slices;
		int off;
		int len;
		int plays;
		int r;
		int burst;
		if (epoch_no == 0 || $urandom_range(0, 2) == 0)
			pick_config();
		n_words = $urandom_range(4, 40);
		region = ($urandom_range(0, 3) == 0) ? SAMPLE_WORDS - $urandom_range(1, 20)
			: $urandom_range(0, SAMPLE_WORDS - 1);
		for (int k = 0; k < n_words; k++)
			send_load_sample(SADDR_W'(region + k), rand_word());
		n_slices = $urandom_range(1, 6);
		for (int k = 0; k < n_slices; k++) begin
			off = $urandom_range(0, n_words - 1);
			case ($urandom_range(0, 9))
				0: len = 0;
				1: len = ($urandom_range(0, 1) == 0) ? 65536 : $urandom_range(n_words, 65536);
				default: len = $urandom_range(1, n_words - off);
			endcase
			send_load_slice(SIDX_W'($urandom), SSTART_W'(region + off), SLEN_W'(len));
		end
		plays = $urandom_range(20, 80);
		for (int k = 0; k < plays; k++) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				send_load_sample(SADDR_W'($urandom), rand_word());
			end else if (r < 5) begin
				send_load_slice(SIDX_W'($urandom), SSTART_W'($urandom),
					SLEN_W'($urandom_range(0, 65536)));
			end else if (r < 9) begin
				// pile up notes to run out of free voices
				burst = $urandom_range(9, 12);
				for (int j = 0; j < burst; j++)
					send_note();
			end else if (r < 35) begin
				send_note();
			end else begin
				send_tick();
			end
		end
		epoch_no++;
	endtask

	// Receiver: stall on a changing pattern, check each mixed word in order.
	int rx_left = 0;
	int rx_mode = 0;
	int rx_count = 0;

	always @(posedge clk) begin : rx_side
		logic [SAMPLE_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (mix_queue.size() == 0) begin
				note_mismatch("unexpected mixed_sample", m_axis_tdata, '0);
			end else begin
				want = mix_queue.pop_front();
				mixes_checked++;
				if (m_axis_tdata !== want)
					note_mismatch("mixed_sample", m_axis_tdata, want);
			end
		end
		if (rx_left == 0) begin
			rx_left = $urandom_range(16, 128);
			rx_mode = $urandom_range(0, 3);
		end
		rx_left--;
		rx_count++;
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 1);
			2: m_axis_tready <= (rx_count % 8) >= 6;
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		wait (idle_cycles >= STALL_LIMIT);
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		for (int v = 0; v < VOICES; v++) begin
			voice_on[v] = 1'b0;
			voice_slice[v] = '0;
			voice_pos[v] = '0;
			voice_gain[v] = '0;
		end

		// Reset state: nothing plays, no kit so notes are dropped.
		add_beat(OP_TICK, '0, 1'b1, 16'h0000);
		add_beat(OP_NOTE_ON, note_beat('0, 7'd36, 8'd127), 1'b0, '0);
		add_beat(OP_TICK, '0, 1'b1, 16'h0000);
		// Count above the table saturates to the table size.
		add_cfg(REG_BASE_NOTE, 7'd0);
		add_cfg(REG_SLICE_COUNT, 7'd31);
		add_beat(OP_LOAD_SAMPLE, sample_beat('0, 16'hffff, 16'h7fff), 1'b0, '0);
		add_beat(OP_LOAD_SAMPLE, sample_beat('0, 16'h0000, 16'h8000), 1'b0, '0);
		add_beat(OP_LOAD_SAMPLE, sample_beat('0, 16'h0001, 16'h0001), 1'b0, '0);
		// Slice 0 wraps past the top of memory; slice 15 is empty.
		add_beat(OP_LOAD_SLICE, slice_beat('0, 4'd0, 16'hffff, 17'd3), 1'b0, '0);
		add_beat(OP_LOAD_SLICE, slice_beat('0, 4'd15, 16'h0000, 17'd0), 1'b0, '0);
		add_beat(OP_LOAD_SLICE, slice_beat('0, 4'd1, 16'h0001, 17'h10000), 1'b0, '0);
		add_beat(OP_NOTE_ON, note_beat('0, 7'd0, 8'd127), 1'b0, '0);
		add_beat(OP_NOTE_ON, note_beat('0, 7'd15, 8'd255), 1'b0, '0);
		add_beat(OP_NOTE_ON, note_beat('0, 7'd16, 8'd200), 1'b0, '0);
		add_beat(OP_TICK, '0, 1'b1, 16'h7fff);
		add_beat(OP_TICK, '0, 1'b1, 16'h8000);
		add_beat(OP_TICK, '0, 1'b1, 16'h0001);
		add_beat(OP_TICK, '0, 1'b1, 16'h0000);
		// Two full-gain voices saturate both ways.
		add_beat(OP_NOTE_ON, note_beat('0, 7'd0, 8'd255), 1'b0, '0);
		add_beat(OP_NOTE_ON, note_beat('0, 7'd0, 8'd255), 1'b0, '0);
		add_beat(OP_TICK, '0, 1'b1, 16'h7fff);
		add_beat(OP_TICK, '0, 1'b1, 16'h8000);
		add_beat(OP_TICK, '0, 1'b1, 16'h0004);
		add_beat(OP_NOTE_ON, note_beat('0, 7'd0, 8'd0), 1'b0, '0);
		add_beat(OP_TICK, '0, 1'b1, 16'h0000);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_CFG)
				set_register(stim_rows[i].cfg_sel, stim_rows[i].cfg_val);
			else
				put_beat(stim_rows[i].op, stim_rows[i].beat, stim_rows[i].typed,
					stim_rows[i].want);
		end

		while (beats_taken - notes_ignored < stim_rows.size() + RANDOM_ITEMS)
			run_epoch();

		s_axis_tvalid <= 1'b0;
		while (mix_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run: %0d beats over %0d kits, %0d mixed words checked, %0d loads",
			beats_taken, epoch_no, mixes_checked, loads);
		$display("run: %0d notes started, %0d dropped, %0d steals, %0d register writes",
			notes_started, notes_ignored, steals, cfg_writes);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/dsvm_pkg.sv
rtl/core/dsvm_ram.sv
rtl/core/drum_sample_voice_mixer_top.sv
test/tb.sv
